FILE: sv/assert_macros.svh
// assertion macros of the tokenizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PBWT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define PBWT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

FILE: sv/pbwt_pkg.sv
// types and constants of the protobuf wire field tokenizer
`default_nettype none

package pbwt_pkg;

  localparam int unsigned MAX_VARINT_BYTES = 10;
  localparam int unsigned SC_W             = 4;
  localparam int unsigned KIND_W           = 3;
  localparam int unsigned WIRE_W           = 3;
  localparam int unsigned FIELD_W          = 32;
  localparam int unsigned VALUE_W          = 64;

  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
    logic       end_of_message;
  } pbwt_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  record_kind;
    logic [FIELD_W-1:0] field_id;
    logic [WIRE_W-1:0]  wire_kind;
    logic [VALUE_W-1:0] field_value;
    logic               truncated;
    logic               payload_last;
  } pbwt_rec_t;

endpackage

`default_nettype wire

FILE: sv/pbwt_in_stage.sv
// input register stage of the tokenizer
`default_nettype none

module pbwt_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_end_of_message,
  input  wire logic              take,
  output pbwt_pkg::pbwt_item_t   item
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       eom_r;
  logic       accept;

  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_data_byte;
      eom_r  <= in_end_of_message;
    end
  end

  assign item.valid          = valid_r;
  assign item.data_byte      = byte_r;
  assign item.end_of_message = eom_r;

endmodule

`default_nettype wire

FILE: sv/pbwt_core.sv
// decode state, per-byte step logic and result register of the tokenizer
`default_nettype none
`include "assert_macros.svh"

module pbwt_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pbwt_pkg::pbwt_item_t item,
  output logic                      take,
  input  wire logic                 pass_payload,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output pbwt_pkg::pbwt_rec_t       rec
);

  localparam logic [2:0] PH_TAG     = 3'd0;
  localparam logic [2:0] PH_VARINT  = 3'd1;
  localparam logic [2:0] PH_FIX64   = 3'd2;
  localparam logic [2:0] PH_FIX32   = 3'd3;
  localparam logic [2:0] PH_LEN     = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_DISCARD = 3'd6;

  localparam logic [2:0] KIND_VARINT  = 3'd0;
  localparam logic [2:0] KIND_FIX64   = 3'd1;
  localparam logic [2:0] KIND_LEN     = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_FIX32   = 3'd4;
  localparam logic [2:0] KIND_BAD     = 3'd5;

  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_FIX64  = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_FIX32  = 3'd5;

  localparam logic [pbwt_pkg::SC_W-1:0] SC_MAX  =
    pbwt_pkg::SC_W'(pbwt_pkg::MAX_VARINT_BYTES);
  localparam logic [pbwt_pkg::SC_W-1:0] SC_FIX8 = pbwt_pkg::SC_W'(8);
  localparam logic [pbwt_pkg::SC_W-1:0] SC_FIX4 = pbwt_pkg::SC_W'(4);

  function automatic logic [5:0] varint_pos(input logic [pbwt_pkg::SC_W-1:0] sc);
    logic [5:0] pos;
    unique case (sc)
      4'd0:    pos = 6'd0;
      4'd1:    pos = 6'd7;
      4'd2:    pos = 6'd14;
      4'd3:    pos = 6'd21;
      4'd4:    pos = 6'd28;
      4'd5:    pos = 6'd35;
      4'd6:    pos = 6'd42;
      4'd7:    pos = 6'd49;
      4'd8:    pos = 6'd56;
      4'd9:    pos = 6'd63;
      default: pos = 6'd0;
    endcase
    return pos;
  endfunction

  function automatic logic [2:0] kind_of_wire(input logic [2:0] w);
    logic [2:0] k;
    unique case (w)
      WIRE_VARINT: k = KIND_VARINT;
      WIRE_FIX64:  k = KIND_FIX64;
      WIRE_LEN:    k = KIND_LEN;
      WIRE_FIX32:  k = KIND_FIX32;
      default:     k = KIND_BAD;
    endcase
    return k;
  endfunction

  logic [2:0]                     phase_r, phase_nxt;
  logic [pbwt_pkg::VALUE_W-1:0]   acc_r, acc_nxt;
  logic [pbwt_pkg::SC_W-1:0]      sc_r, sc_nxt;
  logic [pbwt_pkg::FIELD_W-1:0]   field_r, field_nxt;
  logic [pbwt_pkg::WIRE_W-1:0]    wire_r, wire_nxt;
  logic [pbwt_pkg::VALUE_W-1:0]   left_r, left_nxt;
  logic                           out_valid_r;
  pbwt_pkg::pbwt_rec_t            rec_r, rec_nxt;
  logic                           emit;

  logic [7:0]                     b;
  logic                           eom;
  logic [pbwt_pkg::VALUE_W-1:0]   vt_acc;
  logic [pbwt_pkg::SC_W-1:0]      vt_sc;
  logic                           vt_done;
  logic [pbwt_pkg::VALUE_W-1:0]   fx_acc;
  logic [pbwt_pkg::SC_W-1:0]      fx_sc;
  logic                           fx_done;
  logic                           pay_last;
  logic [2:0]                     tag_kind;

  assign b    = item.data_byte;
  assign eom  = item.end_of_message;
  assign take = item.valid && (!out_valid_r || !out_stall);

  // varint and fixed byte intake
  always_comb begin
    if (sc_r < SC_MAX) begin
      vt_acc = acc_r | ({57'd0, b[6:0]} << varint_pos(sc_r));
      vt_sc  = sc_r + 4'd1;
    end else begin
      vt_acc = acc_r;
      vt_sc  = sc_r;
    end
    vt_done = !b[7] || (vt_sc >= SC_MAX);
    if (sc_r < SC_FIX8) begin
      fx_acc = acc_r | ({56'd0, b} << {sc_r[2:0], 3'b000});
      fx_sc  = sc_r + 4'd1;
    end else begin
      fx_acc = acc_r;
      fx_sc  = sc_r;
    end
    fx_done = fx_sc >= ((phase_r == PH_FIX64) ? SC_FIX8 : SC_FIX4);
  end

  assign pay_last = left_r <= 64'd1;
  assign tag_kind = kind_of_wire(vt_acc[2:0]);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    sc_nxt    = sc_r;
    field_nxt = field_r;
    wire_nxt  = wire_r;
    left_nxt  = left_r;
    emit      = 1'b0;
    rec_nxt.record_kind  = KIND_VARINT;
    rec_nxt.field_value  = '0;
    rec_nxt.truncated    = 1'b0;
    rec_nxt.payload_last = 1'b0;

    unique case (phase_r)
      PH_VARINT: begin
        if (vt_done || eom) begin
          emit                 = 1'b1;
          rec_nxt.record_kind  = KIND_VARINT;
          rec_nxt.field_value  = vt_acc;
          rec_nxt.truncated    = !vt_done;
          acc_nxt              = '0;
          sc_nxt               = '0;
          phase_nxt            = PH_TAG;
        end else begin
          acc_nxt = vt_acc;
          sc_nxt  = vt_sc;
        end
      end
      PH_FIX64, PH_FIX32: begin
        if (fx_done || eom) begin
          emit                 = 1'b1;
          rec_nxt.record_kind  = (phase_r == PH_FIX64) ? KIND_FIX64 : KIND_FIX32;
          rec_nxt.field_value  = fx_done ? fx_acc : '0;
          rec_nxt.truncated    = !fx_done;
          acc_nxt              = '0;
          sc_nxt               = '0;
          phase_nxt            = PH_TAG;
        end else begin
          acc_nxt = fx_acc;
          sc_nxt  = fx_sc;
        end
      end
      PH_LEN: begin
        if (vt_done || eom) begin
          emit                 = 1'b1;
          rec_nxt.record_kind  = KIND_LEN;
          rec_nxt.field_value  = vt_acc;
          rec_nxt.truncated    = !vt_done || (eom && (vt_acc != '0));
          acc_nxt              = '0;
          sc_nxt               = '0;
          if (eom || (vt_acc == '0)) begin
            phase_nxt = PH_TAG;
          end else begin
            phase_nxt = PH_PAYLOAD;
            left_nxt  = vt_acc;
          end
        end else begin
          acc_nxt = vt_acc;
          sc_nxt  = vt_sc;
        end
      end
      PH_PAYLOAD: begin
        left_nxt = pay_last ? '0 : left_r - 64'd1;
        if (pay_last) begin
          phase_nxt = PH_TAG;
        end
        if (pass_payload) begin
          emit                 = 1'b1;
          rec_nxt.record_kind  = KIND_PAYLOAD;
          rec_nxt.field_value  = {56'd0, b};
          rec_nxt.truncated    = eom && !pay_last;
          rec_nxt.payload_last = pay_last || eom;
        end
      end
      PH_DISCARD: begin
        emit = 1'b0;
      end
      default: begin
        if (vt_done || eom) begin
          field_nxt           = vt_acc[34:3];
          wire_nxt            = vt_acc[2:0];
          acc_nxt             = '0;
          sc_nxt              = '0;
          rec_nxt.record_kind = tag_kind;
          if (eom) begin
            emit              = 1'b1;
            rec_nxt.truncated = 1'b1;
            phase_nxt         = PH_TAG;
          end else begin
            unique case (tag_kind)
              KIND_VARINT: phase_nxt = PH_VARINT;
              KIND_FIX64:  phase_nxt = PH_FIX64;
              KIND_LEN:    phase_nxt = PH_LEN;
              KIND_FIX32:  phase_nxt = PH_FIX32;
              default: begin
                phase_nxt = PH_DISCARD;
                emit      = 1'b1;
              end
            endcase
          end
        end else begin
          acc_nxt = vt_acc;
          sc_nxt  = vt_sc;
        end
      end
    endcase

    // message end always returns to tag decode
    if (eom) begin
      phase_nxt = PH_TAG;
      acc_nxt   = '0;
      sc_nxt    = '0;
      left_nxt  = '0;
    end

    rec_nxt.field_id  = field_nxt;
    rec_nxt.wire_kind = wire_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      acc_r   <= '0;
      sc_r    <= '0;
      field_r <= '0;
      wire_r  <= '0;
      left_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      sc_r    <= sc_nxt;
      field_r <= field_nxt;
      wire_r  <= wire_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      rec_r <= rec_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign rec       = rec_r;

  `PBWT_ASSERT_SAME(a_last_only_payload,
    out_valid_r && rec_r.payload_last, rec_r.record_kind == KIND_PAYLOAD)
  `PBWT_ASSERT_SAME(a_bad_wire_zero,
    out_valid_r && (rec_r.record_kind == KIND_BAD), rec_r.field_value == '0)
  `PBWT_ASSERT_NEXT(a_eom_to_tag,
    take && eom, (phase_r == PH_TAG) && (sc_r == '0) && (left_r == '0))
  `PBWT_ASSERT_SAME(a_count_bound, 1'b1, sc_r <= SC_MAX)

endmodule

`default_nettype wire

FILE: sv/protobuf_wire_field_tokenizer_unit.sv
// top level of the protobuf wire field tokenizer
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in       | in_valid / in_stall   | data_byte, end_of_message
//  out      | out_valid / out_stall | record_kind, field_id, wire_kind,
//           |                       | field_value, truncated, payload_last
//  cfg      | cfg_write_en          | cfg_pass_payload
//
// one byte per cycle while out_stall is low; a byte is held in the input register until
// the core takes it, and its record (if any) is then written into the result register
// the state update and result decision for a byte are computed in the same cycle
// reset: synchronous active-low rst_n, pass_payload returns to 1
// out_stall holds the result register and backs up into in_stall
`default_nettype none

module protobuf_wire_field_tokenizer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_record_kind,
  output logic [31:0]      out_field_id,
  output logic [2:0]       out_wire_kind,
  output logic [63:0]      out_field_value,
  output logic             out_truncated,
  output logic             out_payload_last,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_pass_payload
);

  logic                 pass_payload_r;
  logic                 take;
  pbwt_pkg::pbwt_item_t item;
  pbwt_pkg::pbwt_rec_t  rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_payload_r <= 1'b1;
    end else if (cfg_write_en) begin
      pass_payload_r <= cfg_pass_payload;
    end
  end

  pbwt_in_stage u_in_stage (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .take              (take),
    .item              (item)
  );

  pbwt_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item         (item),
    .take         (take),
    .pass_payload (pass_payload_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rec          (rec)
  );

  assign out_record_kind  = rec.record_kind;
  assign out_field_id     = rec.field_id;
  assign out_wire_kind    = rec.wire_kind;
  assign out_field_value  = rec.field_value;
  assign out_truncated    = rec.truncated;
  assign out_payload_last = rec.payload_last;

endmodule

`default_nettype wire

FILE: verif/protobuf_wire_field_tokenizer_unit_test.sv
// self-checking testbench for the protobuf wire field tokenizer: byte-level predictor, random idling
`timescale 1ns / 100ps

module protobuf_wire_field_tokenizer_unit_test;

  localparam logic [2:0] KIND_VARINT   = 3'd0;
  localparam logic [2:0] KIND_FIX64    = 3'd1;
  localparam logic [2:0] KIND_LEN_HDR  = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD  = 3'd3;
  localparam logic [2:0] KIND_FIX32    = 3'd4;
  localparam logic [2:0] KIND_BAD_WIRE = 3'd5;

  localparam logic [2:0] WIRE_VARINT      = 3'd0;
  localparam logic [2:0] WIRE_FIX64       = 3'd1;
  localparam logic [2:0] WIRE_LEN         = 3'd2;
  localparam logic [2:0] WIRE_GROUP_START = 3'd3;
  localparam logic [2:0] WIRE_GROUP_END   = 3'd4;
  localparam logic [2:0] WIRE_FIX32       = 3'd5;
  localparam logic [2:0] WIRE_RSVD6       = 3'd6;
  localparam logic [2:0] WIRE_RSVD7       = 3'd7;

  localparam int RANDOM_BYTES = 1550;

  typedef enum logic [2:0] {
    ST_TAG, ST_VARINT, ST_FIX64, ST_FIX32, ST_LEN, ST_PAYLOAD, ST_DISCARD
  } parse_state_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_record_kind;
  logic [31:0] out_field_id;
  logic [2:0]  out_wire_kind;
  logic [63:0] out_field_value;
  logic        out_truncated;
  logic        out_payload_last;
  logic        cfg_write_en = 1'b0;
  logic        cfg_pass_payload = 1'b1;

  // predictor state
  parse_state_e parse_state = ST_TAG;
  logic [63:0]  value_acc = '0;
  int           byte_cnt = 0;
  logic [31:0]  tag_field = '0;
  logic [2:0]   tag_wire = '0;
  logic [63:0]  payload_left = '0;
  logic         pass_q = 1'b1;

  pbwt_pkg::pbwt_rec_t pending_records[$];
  pbwt_pkg::pbwt_rec_t want;
  logic [7:0]  msg_bytes[$];
  int          error_count = 0;
  int          useful_count = 0;
  int          hold_left = 0;
  int          stall_pick;
  bit          steady_feed = 1'b0;

  protobuf_wire_field_tokenizer_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_record_kind   (out_record_kind),
    .out_field_id      (out_field_id),
    .out_wire_kind     (out_wire_kind),
    .out_field_value   (out_field_value),
    .out_truncated     (out_truncated),
    .out_payload_last  (out_payload_last),
    .cfg_write_en      (cfg_write_en),
    .cfg_pass_payload  (cfg_pass_payload)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void push_record(logic [2:0] kind, logic [63:0] value, logic trunc,
                                      logic last);
    pbwt_pkg::pbwt_rec_t rec;
    rec.record_kind  = kind;
    rec.field_id     = tag_field;
    rec.wire_kind    = tag_wire;
    rec.field_value  = value;
    rec.truncated    = trunc;
    rec.payload_last = last;
    pending_records.push_back(rec);
  endfunction

  function automatic bit absorb_varint(logic [7:0] b);
    if (byte_cnt < pbwt_pkg::MAX_VARINT_BYTES) begin
      if (7 * byte_cnt < 64) value_acc |= 64'(b[6:0]) << (7 * byte_cnt);
      byte_cnt++;
    end
    return !b[7] || byte_cnt >= pbwt_pkg::MAX_VARINT_BYTES;
  endfunction

  // returns 1 when the byte is neither discarded nor a skipped payload byte
  function automatic bit tokenize_byte(logic [7:0] b, logic eom);
    bit          done;
    bit          last;
    bit          useful;
    logic [63:0] v;
    logic [2:0]  kind;
    useful = 1'b1;
    case (parse_state)
      ST_VARINT: begin
        done = absorb_varint(b);
        if (done || eom) begin
          v = value_acc;
          value_acc = '0;
          byte_cnt = 0;
          parse_state = ST_TAG;
          push_record(KIND_VARINT, v, !done, 1'b0);
        end
      end
      ST_FIX64, ST_FIX32: begin
        if (byte_cnt < 8) begin
          value_acc |= 64'(b) << (8 * byte_cnt);
          byte_cnt++;
        end
        done = byte_cnt >= ((parse_state == ST_FIX64) ? 8 : 4);
        if (done || eom) begin
          kind = (parse_state == ST_FIX64) ? KIND_FIX64 : KIND_FIX32;
          v = done ? value_acc : '0;
          value_acc = '0;
          byte_cnt = 0;
          parse_state = ST_TAG;
          push_record(kind, v, !done, 1'b0);
        end
      end
      ST_LEN: begin
        done = absorb_varint(b);
        if (done || eom) begin
          v = value_acc;
          value_acc = '0;
          byte_cnt = 0;
          if (eom || v == 0) begin
            parse_state = ST_TAG;
          end else begin
            parse_state = ST_PAYLOAD;
            payload_left = v;
          end
          push_record(KIND_LEN_HDR, v, !done || (eom && v != 0), 1'b0);
        end
      end
      ST_PAYLOAD: begin
        last = payload_left <= 1;
        payload_left = last ? '0 : payload_left - 1;
        if (last) parse_state = ST_TAG;
        if (pass_q) push_record(KIND_PAYLOAD, {56'd0, b}, eom && !last, last || eom);
        else useful = 1'b0;
      end
      ST_DISCARD: useful = 1'b0;
      default: begin
        done = absorb_varint(b);
        if (done || eom) begin
          tag_field = value_acc[34:3];
          tag_wire  = value_acc[2:0];
          value_acc = '0;
          byte_cnt = 0;
          case (tag_wire)
            WIRE_VARINT: kind = KIND_VARINT;
            WIRE_FIX64:  kind = KIND_FIX64;
            WIRE_LEN:    kind = KIND_LEN_HDR;
            WIRE_FIX32:  kind = KIND_FIX32;
            default:     kind = KIND_BAD_WIRE;
          endcase
          if (eom) begin
            push_record(kind, '0, 1'b1, 1'b0);
          end else begin
            case (kind)
              KIND_VARINT:  parse_state = ST_VARINT;
              KIND_FIX64:   parse_state = ST_FIX64;
              KIND_LEN_HDR: parse_state = ST_LEN;
              KIND_FIX32:   parse_state = ST_FIX32;
              default: begin
                parse_state = ST_DISCARD;
                push_record(KIND_BAD_WIRE, '0, 1'b0, 1'b0);
              end
            endcase
          end
        end
      end
    endcase
    if (eom) begin
      parse_state = ST_TAG;
      value_acc = '0;
      byte_cnt = 0;
      payload_left = '0;
    end
    return useful;
  endfunction

  // receiver side: random stalls, mostly short, with calm stretches
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 70) begin
        out_stall = 1'b0;
      end else if (stall_pick < 92) begin
        out_stall = 1'b1;
        hold_left = $urandom_range(0, 2);
      end else if (stall_pick < 97) begin
        out_stall = 1'b1;
        hold_left = $urandom_range(3, 9);
      end else if (stall_pick < 99) begin
        out_stall = 1'b1;
        hold_left = $urandom_range(19, 39);
      end else begin
        out_stall = 1'b0;
        hold_left = $urandom_range(50, 200);
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_records.size() == 0) begin
        $error("unexpected transaction: record_kind %0d field_value 0x%0h",
               out_record_kind, out_field_value);
        error_count++;
      end else begin
        want = pending_records.pop_front();
        check_field("record_kind", 64'(want.record_kind), 64'(out_record_kind));
        check_field("field_id", 64'(want.field_id), 64'(out_field_id));
        check_field("wire_kind", 64'(want.wire_kind), 64'(out_wire_kind));
        check_field("field_value", want.field_value, out_field_value);
        check_field("truncated", 64'(want.truncated), 64'(out_truncated));
        check_field("payload_last", 64'(want.payload_last), 64'(out_payload_last));
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic eom);
    int gap;
    int pick;
    @(negedge clk);
    pick = $urandom_range(0, 99);
    if (steady_feed || pick < 60) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else if (pick < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 40);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data_byte = b;
    in_end_of_message = eom;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (tokenize_byte(b, eom)) useful_count++;
  endtask

  task automatic send_bytes(bit close);
    for (int i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], close && (i == msg_bytes.size() - 1));
    msg_bytes.delete();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_records.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_pass_payload(logic v);
    wait_drained();
    cfg_pass_payload = v;
    cfg_write_en = 1'b1;
    @(posedge clk);
    pass_q = v;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  function automatic void add_varint(logic [63:0] v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      msg_bytes.push_back(b);
    end while (v != 0);
  endfunction

  function automatic logic [63:0] tag_of(logic [31:0] field, logic [2:0] wire_kind);
    return {29'd0, field, wire_kind};
  endfunction

  function automatic logic [63:0] rand_wide();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v >> $urandom_range(0, 63);
  endfunction

  function automatic logic [63:0] random_tag(logic [2:0] wire_kind);
    int          pick;
    logic [63:0] wide;
    pick = $urandom_range(0, 99);
    wide = rand_wide();
    if (pick < 30) return tag_of($urandom_range(1, 15), wire_kind);
    if (pick < 75) return tag_of($urandom >> $urandom_range(0, 31), wire_kind);
    if (pick < 85) return tag_of('1, wire_kind);
    if (pick < 90) return tag_of('0, wire_kind);
    // tag of up to 64 bits, which may be wider than the field number can hold
    return {wide[63:3], wire_kind};
  endfunction

  // appends one field; returns 1 when nothing may follow it
  function automatic bit add_random_field();
    int          pick;
    int          n;
    logic [63:0] len;
    logic [2:0]  w;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      add_varint(random_tag(WIRE_VARINT));
      if ($urandom_range(0, 19) == 0) begin
        repeat (9) msg_bytes.push_back(8'($urandom) | 8'h80);
        msg_bytes.push_back(8'($urandom));
      end else begin
        add_varint(rand_wide());
      end
    end else if (pick < 45) begin
      add_varint(random_tag(WIRE_FIX64));
      repeat (8) msg_bytes.push_back(8'($urandom));
    end else if (pick < 60) begin
      add_varint(random_tag(WIRE_FIX32));
      repeat (4) msg_bytes.push_back(8'($urandom));
    end else if (pick < 92) begin
      add_varint(random_tag(WIRE_LEN));
      n = $urandom_range(0, 99);
      if (n < 5) begin
        // length far beyond the message end
        add_varint(rand_wide() | 64'h100);
        repeat ($urandom_range(0, 10)) msg_bytes.push_back(8'($urandom));
        return 1'b1;
      end
      len = (n < 75) ? 64'($urandom_range(0, 6)) : 64'($urandom_range(7, 40));
      add_varint(len);
      repeat (len) msg_bytes.push_back(8'($urandom));
    end else begin
      case ($urandom_range(0, 3))
        0: w = WIRE_GROUP_START;
        1: w = WIRE_GROUP_END;
        2: w = WIRE_RSVD6;
        default: w = WIRE_RSVD7;
      endcase
      add_varint(random_tag(w));
      repeat ($urandom_range(0, 5)) msg_bytes.push_back(8'($urandom));
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_random_message();
    bit closed;
    int nfields;
    int cut;
    steady_feed = ($urandom_range(0, 99) < 15);
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 16)) msg_bytes.push_back(8'($urandom));
    end else begin
      nfields = $urandom_range(1, 5);
      closed = 1'b0;
      while (nfields != 0 && !closed) begin
        closed = add_random_field();
        nfields--;
      end
    end
    if ($urandom_range(0, 99) < 20) begin
      cut = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
    end
    send_bytes(1'b1);
    steady_feed = 1'b0;
  endtask

  task automatic test_directed_records();
    // one-byte payload, zero length, fixed32 completing on the final byte
    add_varint(tag_of(1, WIRE_LEN));
    msg_bytes.push_back(8'h01);
    msg_bytes.push_back(8'hFF);
    add_varint(tag_of(2, WIRE_LEN));
    msg_bytes.push_back(8'h00);
    add_varint(tag_of(3, WIRE_FIX32));
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'h00);
    msg_bytes.push_back(8'h80);
    send_bytes(1'b1);
    // bad wire type on the final byte
    add_varint(tag_of(1, WIRE_RSVD7));
    send_bytes(1'b1);
    // tag cut short
    msg_bytes.push_back(8'h80);
    send_bytes(1'b1);
    // fixed64 cut short
    add_varint(tag_of(1, WIRE_FIX64));
    msg_bytes.push_back(8'h11);
    send_bytes(1'b1);
    // payload cut short
    add_varint(tag_of(2, WIRE_LEN));
    msg_bytes.push_back(8'h05);
    msg_bytes.push_back(8'hAB);
    send_bytes(1'b1);
    // length cut short
    add_varint(tag_of(2, WIRE_LEN));
    msg_bytes.push_back(8'h85);
    send_bytes(1'b1);
    // nonzero length on the final byte
    add_varint(tag_of(2, WIRE_LEN));
    msg_bytes.push_back(8'h03);
    send_bytes(1'b1);
    // bad wire type, then discarded bytes
    add_varint(tag_of(1, WIRE_GROUP_START));
    msg_bytes.push_back(8'hFF);
    send_bytes(1'b1);
  endtask

  task automatic test_skipped_payload();
    write_pass_payload(1'b0);
    add_varint(tag_of(4, WIRE_LEN));
    msg_bytes.push_back(8'h05);
    msg_bytes.push_back(8'h11);
    send_bytes(1'b1);
    // register flipped in the middle of a payload
    add_varint(tag_of(4, WIRE_LEN));
    msg_bytes.push_back(8'h02);
    msg_bytes.push_back(8'h33);
    send_bytes(1'b0);
    write_pass_payload(1'b1);
    msg_bytes.push_back(8'h44);
    send_bytes(1'b1);
  endtask

  task automatic test_random_messages();
    int goal;
    goal = useful_count;
    for (int p = 0; p < 6; p++) begin
      write_pass_payload((p == 1 || p == 4) ? 1'b0 : 1'b1);
      goal += RANDOM_BYTES / 6;
      while (useful_count < goal) send_random_message();
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    test_directed_records();
    test_skipped_payload();
    test_random_messages();
    wait_drained();
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
